// ===== rtl/elfrel_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elfrel_pkg
// shared types and constants for the relocation patcher
// ----------------------------------------------------------------------------
package elfrel_pkg;

  localparam int SEGMENT_SLOTS = 8;
  localparam int SLOT_W        = $clog2(SEGMENT_SLOTS);
  localparam int CNT_W         = $clog2(SEGMENT_SLOTS + 1);
  localparam int ADDR_W        = 64;
  localparam int ENTRY_W       = 3 * ADDR_W;

  localparam logic [ADDR_W-1:0] VADDR_HINT = 64'h0000_0000_0040_0000;

  // configuration register indexes
  localparam logic [1:0] CFG_SEG_COUNT = 2'd0;
  localparam logic [1:0] CFG_LOAD_BASE = 2'd1;

  // operations
  localparam logic OP_SLOT_WRITE = 1'b0;
  localparam logic OP_RELOCATE   = 1'b1;

  // relocation types
  localparam logic [31:0] RT_NONE     = 32'd0;
  localparam logic [31:0] RT_64       = 32'd1;
  localparam logic [31:0] RT_PC32     = 32'd2;
  localparam logic [31:0] RT_PLT32    = 32'd4;
  localparam logic [31:0] RT_RELATIVE = 32'd8;
  localparam logic [31:0] RT_GOTPCREL = 32'd9;
  localparam logic [31:0] RT_32       = 32'd10;
  localparam logic [31:0] RT_32S      = 32'd11;

  // result status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_TGT_UNMAP = 3'd1;
  localparam logic [2:0] STAT_SYM_UNMAP = 3'd2;
  localparam logic [2:0] STAT_OVERFLOW  = 3'd3;
  localparam logic [2:0] STAT_BAD_TYPE  = 3'd4;

  // write kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_W64  = 2'd1;
  localparam logic [1:0] KIND_W32  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TSUM,
    S_LOOKUP,
    S_CMP,
    S_XLAT,
    S_EVAL,
    S_CALC,
    S_PCCHK,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_TGT,
    PH_SYM,
    PH_ADD
  } phase_t;

  typedef struct packed {
    logic [ADDR_W-1:0] seg_start;
    logic [ADDR_W-1:0] seg_end;
    logic [ADDR_W-1:0] seg_loaded;
  } slot_t;

endpackage

`default_nettype wire

// ===== rtl/elf_relocation_patcher_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elf_relocation_patcher_core
// x86-64 rela relocation evaluator over a segment mapping table
// ----------------------------------------------------------------------------
// channel  direction  handshake               payload
// in       in         start & !busy           operation, slot, segment, reloc
// out      out        out_valid (one cycle)   status, kind, address, value
// cfg      in         cfg_valid & cfg_ready   cfg_index, cfg_wdata
//
// a slot write goes straight to the result strobe; a relocation sums the
// target address, then each slot search walks the slots in order with a lookup
// and a compare per slot and a translate or end step, and up to three searches
// run (target, symbol, relative addend) on one table port
// reset is synchronous and active low; the slot table is not cleared
// results cannot be stalled; the next request is taken after the strobe
// ----------------------------------------------------------------------------
module elf_relocation_patcher_core (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire                         in_operation,
  input  wire  [2:0]                  in_slot_index,
  input  wire  [63:0]                 in_seg_start,
  input  wire  [63:0]                 in_seg_end,
  input  wire  [63:0]                 in_seg_loaded,
  input  wire  [31:0]                 in_reloc_code,
  input  wire                         in_has_symbol,
  input  wire  [63:0]                 in_symbol_value,
  input  wire  [63:0]                 in_section_address,
  input  wire  [63:0]                 in_reloc_offset,
  input  wire  signed [63:0]          in_addend,
  output logic                        out_valid,
  output logic [2:0]                  out_status,
  output logic [1:0]                  out_write_kind,
  output logic [63:0]                 out_write_address,
  output logic [63:0]                 out_write_value,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire  [1:0]                  cfg_index,
  input  wire  [63:0]                 cfg_wdata
);
  import elfrel_pkg::*;

  slot_t             mem [SEGMENT_SLOTS];
  slot_t             q_r;

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] diff_r, diff_nxt;
  logic [ADDR_W-1:0] loaded_r, loaded_nxt;
  logic [ADDR_W-1:0] taddr_r, taddr_nxt;
  logic [ADDR_W-1:0] sval_r, sval_nxt;
  logic [ADDR_W-1:0] sum_r, sum_nxt;
  logic [31:0]       type_r, type_nxt;
  logic              has_sym_r, has_sym_nxt;
  logic [ADDR_W-1:0] symv_r, symv_nxt;
  logic [ADDR_W-1:0] addend_r, addend_nxt;
  logic [ADDR_W-1:0] sec_r, sec_nxt;
  logic [ADDR_W-1:0] off_r, off_nxt;
  logic [2:0]        status_r, status_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [ADDR_W-1:0] wval_r, wval_nxt;
  logic [3:0]        seg_count_r;
  logic [ADDR_W-1:0] load_base_r;

  logic              accept;
  logic [CNT_W-1:0]  slots_lim;
  logic              hit;
  logic [ADDR_W-1:0] xlat;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);

  assign out_valid         = (state_r == S_DONE);
  assign out_status        = status_r;
  assign out_write_kind    = kind_r;
  assign out_write_address = taddr_r;
  assign out_write_value   = wval_r;

  assign slots_lim = (seg_count_r > 4'(SEGMENT_SLOTS)) ? CNT_W'(SEGMENT_SLOTS)
                                                        : CNT_W'(seg_count_r);
  assign hit  = (addr_r >= q_r.seg_start) && (addr_r < q_r.seg_end);
  assign xlat = loaded_r + diff_r;

  // slot table
  always_ff @(posedge clk) begin
    if (accept && in_operation == OP_SLOT_WRITE &&
        32'(in_slot_index) < SEGMENT_SLOTS) begin
      mem[in_slot_index[SLOT_W-1:0]] <= '{in_seg_start, in_seg_end, in_seg_loaded};
    end
    q_r <= mem[idx_r[SLOT_W-1:0]];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= '0;
      load_base_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SEG_COUNT: seg_count_r <= cfg_wdata[3:0];
        CFG_LOAD_BASE: load_base_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_TGT;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    diff_r    <= diff_nxt;
    loaded_r  <= loaded_nxt;
    taddr_r   <= taddr_nxt;
    sval_r    <= sval_nxt;
    sum_r     <= sum_nxt;
    type_r    <= type_nxt;
    has_sym_r <= has_sym_nxt;
    symv_r    <= symv_nxt;
    addend_r  <= addend_nxt;
    sec_r     <= sec_nxt;
    off_r     <= off_nxt;
    status_r  <= status_nxt;
    kind_r    <= kind_nxt;
    wval_r    <= wval_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    addr_nxt    = addr_r;
    diff_nxt    = diff_r;
    loaded_nxt  = loaded_r;
    taddr_nxt   = taddr_r;
    sval_nxt    = sval_r;
    sum_nxt     = sum_r;
    type_nxt    = type_r;
    has_sym_nxt = has_sym_r;
    symv_nxt    = symv_r;
    addend_nxt  = addend_r;
    sec_nxt     = sec_r;
    off_nxt     = off_r;
    status_nxt  = status_r;
    kind_nxt    = kind_r;
    wval_nxt    = wval_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt  = STAT_OK;
          kind_nxt    = KIND_NONE;
          wval_nxt    = '0;
          taddr_nxt   = '0;
          sval_nxt    = '0;
          type_nxt    = in_reloc_code;
          has_sym_nxt = in_has_symbol;
          symv_nxt    = in_symbol_value;
          addend_nxt  = in_addend;
          sec_nxt     = in_section_address;
          off_nxt     = in_reloc_offset;
          state_nxt   = (in_operation == OP_RELOCATE) ? S_TSUM : S_DONE;
        end
      end
      S_TSUM: begin
        addr_nxt  = sec_r + off_r;
        phase_nxt = PH_TGT;
        idx_nxt   = '0;
        state_nxt = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (idx_r < slots_lim) begin
          state_nxt = S_CMP;
        end else begin
          // no slot holds the address
          case (phase_r)
            PH_TGT: begin
              status_nxt = STAT_TGT_UNMAP;
              state_nxt  = S_DONE;
            end
            PH_SYM: begin
              status_nxt = STAT_SYM_UNMAP;
              state_nxt  = S_DONE;
            end
            default: begin
              kind_nxt  = KIND_W64;
              wval_nxt  = load_base_r + addend_r;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_CMP: begin
        diff_nxt   = addr_r - q_r.seg_start;
        loaded_nxt = q_r.seg_loaded;
        if (hit) begin
          state_nxt = S_XLAT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_LOOKUP;
        end
      end
      S_XLAT: begin
        case (phase_r)
          PH_TGT: begin
            if (xlat == '0) begin
              status_nxt = STAT_TGT_UNMAP;
              state_nxt  = S_DONE;
            end else begin
              taddr_nxt = xlat;
              if (has_sym_r && symv_r != '0) begin
                phase_nxt = PH_SYM;
                addr_nxt  = symv_r;
                idx_nxt   = '0;
                state_nxt = S_LOOKUP;
              end else begin
                state_nxt = S_EVAL;
              end
            end
          end
          PH_SYM: begin
            if (xlat == '0) begin
              status_nxt = STAT_SYM_UNMAP;
              state_nxt  = S_DONE;
            end else begin
              sval_nxt  = xlat;
              state_nxt = S_EVAL;
            end
          end
          default: begin
            kind_nxt  = KIND_W64;
            wval_nxt  = xlat;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_EVAL: begin
        sum_nxt   = sval_r + addend_r;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        state_nxt = S_DONE;
        case (type_r)
          RT_NONE: ;
          RT_64: begin
            kind_nxt = KIND_W64;
            wval_nxt = sum_r;
          end
          RT_PC32, RT_PLT32, RT_GOTPCREL: begin
            sum_nxt   = sum_r - taddr_r;
            state_nxt = S_PCCHK;
          end
          RT_32, RT_32S: begin
            kind_nxt = KIND_W32;
            wval_nxt = {32'd0, sum_r[31:0]};
          end
          RT_RELATIVE: begin
            if (!addend_r[63] && addend_r >= VADDR_HINT) begin
              phase_nxt = PH_ADD;
              addr_nxt  = addend_r;
              idx_nxt   = '0;
              state_nxt = S_LOOKUP;
            end else begin
              kind_nxt = KIND_W64;
              wval_nxt = load_base_r + addend_r;
            end
          end
          default: status_nxt = STAT_BAD_TYPE;
        endcase
      end
      S_PCCHK: begin
        // fits int32 when bits 63..31 are all equal
        if (sum_r[63:31] == '0 || sum_r[63:31] == '1) begin
          kind_nxt = KIND_W32;
          wval_nxt = {32'd0, sum_r[31:0]};
        end else begin
          status_nxt = STAT_OVERFLOW;
        end
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_write_kind == KIND_NONE) |-> (out_write_value == '0))
    else $error("write value nonzero with no write");

  a_err_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |-> (out_write_kind == KIND_NONE))
    else $error("write requested on error status");

  a_w32_upper: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_write_kind == KIND_W32) |-> (out_write_value[63:32] == '0))
    else $error("32-bit write value not zero-extended");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_elf_relocation_patcher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_elf_relocation_patcher_core
// self-checking bench for the segment-mapped relocation patcher: a directed
// set of slot writes and relocations covering every type and corner, then
// random batches under varied segment counts, load bases and request gaps,
// every result checked field by field against an in-bench predictor
// ----------------------------------------------------------------------------
module tb_elf_relocation_patcher_core;
  import elfrel_pkg::*;

  localparam logic [63:0] I32_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] I32_MIN = 64'hFFFF_FFFF_8000_0000;
  localparam int          SETTLE  = 64;

  typedef struct packed {
    logic        op;
    logic [2:0]  slot;
    logic [63:0] seg_start;
    logic [63:0] seg_end;
    logic [63:0] seg_loaded;
    logic [31:0] reloc_code;
    logic        has_sym;
    logic [63:0] sym;
    logic [63:0] sect;
    logic [63:0] off;
    logic [63:0] addend;
  } reloc_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  kind;
    logic [63:0] addr;
    logic [63:0] value;
  } patch_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_operation = 1'b0;
  logic [2:0]  in_slot_index = '0;
  logic [63:0] in_seg_start = '0;
  logic [63:0] in_seg_end = '0;
  logic [63:0] in_seg_loaded = '0;
  logic [31:0] in_reloc_code = '0;
  logic        in_has_symbol = 1'b0;
  logic [63:0] in_symbol_value = '0;
  logic [63:0] in_section_address = '0;
  logic [63:0] in_reloc_offset = '0;
  logic [63:0] in_addend = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [1:0]  out_write_kind;
  logic [63:0] out_write_address;
  logic [63:0] out_write_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  elf_relocation_patcher_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_slot_index(in_slot_index),
    .in_seg_start(in_seg_start), .in_seg_end(in_seg_end),
    .in_seg_loaded(in_seg_loaded), .in_reloc_code(in_reloc_code),
    .in_has_symbol(in_has_symbol), .in_symbol_value(in_symbol_value),
    .in_section_address(in_section_address), .in_reloc_offset(in_reloc_offset),
    .in_addend(in_addend), .out_valid(out_valid), .out_status(out_status),
    .out_write_kind(out_write_kind), .out_write_address(out_write_address),
    .out_write_value(out_write_value), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  reloc_req_t req_backlog [$];
  patch_t     patch_due [$];
  int         n_issued = 0;
  int         n_accepted = 0;
  int         idle_pct = 0;
  int         mismatch_count = 0;

  // predictor copy of the mapping table and registers
  logic [63:0] map_start [SEGMENT_SLOTS];
  logic [63:0] map_end [SEGMENT_SLOTS];
  logic [63:0] map_loaded [SEGMENT_SLOTS];
  logic [3:0]  map_count = '0;
  logic [63:0] map_load_base = '0;

  // stimulus-side view of the layout, used to aim addresses
  logic [63:0] lay_start [8];
  logic [63:0] lay_end [8];

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  function automatic bit map_lookup(input logic [63:0] va, output logic [63:0] la);
    int n;
    n = (map_count > SEGMENT_SLOTS) ? SEGMENT_SLOTS : int'(map_count);
    la = '0;
    for (int i = 0; i < n; i++) begin
      if (va >= map_start[i] && va < map_end[i]) begin
        la = map_loaded[i] + (va - map_start[i]);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic patch_t predict_patch(input reloc_req_t r);
    patch_t      p;
    logic [63:0] tgt;
    logic [63:0] sval;
    logic [63:0] sum;
    logic [63:0] diff;
    logic [63:0] rel;
    logic [63:0] hit;
    p = '0;
    sval = '0;
    if (r.op == OP_SLOT_WRITE) begin
      map_start[r.slot] = r.seg_start;
      map_end[r.slot] = r.seg_end;
      map_loaded[r.slot] = r.seg_loaded;
      return p;
    end
    tgt = r.sect + r.off;
    if (!map_lookup(tgt, p.addr) || p.addr == '0) begin
      p.status = STAT_TGT_UNMAP;
      p.addr = '0;
      return p;
    end
    if (r.has_sym && r.sym != '0) begin
      if (!map_lookup(r.sym, sval) || sval == '0) begin
        p.status = STAT_SYM_UNMAP;
        return p;
      end
    end
    sum = sval + r.addend;
    case (r.reloc_code)
      RT_NONE: ;
      RT_64: begin
        p.kind = KIND_W64;
        p.value = sum;
      end
      RT_PC32, RT_PLT32, RT_GOTPCREL: begin
        diff = sum - p.addr;
        if (diff + 64'h8000_0000 >= 64'h1_0000_0000) begin
          p.status = STAT_OVERFLOW;
        end else begin
          p.kind = KIND_W32;
          p.value = {32'h0, diff[31:0]};
        end
      end
      RT_32, RT_32S: begin
        p.kind = KIND_W32;
        p.value = {32'h0, sum[31:0]};
      end
      RT_RELATIVE: begin
        rel = map_load_base + r.addend;
        if (!r.addend[63] && r.addend >= VADDR_HINT && map_lookup(r.addend, hit))
          rel = hit;
        p.kind = KIND_W64;
        p.value = rel;
      end
      default: p.status = STAT_BAD_TYPE;
    endcase
    return p;
  endfunction

  // driver: presents the next request once the previous one is taken
  always @(negedge clk) begin : drive
    reloc_req_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (n_accepted == n_issued) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = req_backlog.pop_front();
        in_operation <= nxt.op;
        in_slot_index <= nxt.slot;
        in_seg_start <= nxt.seg_start;
        in_seg_end <= nxt.seg_end;
        in_seg_loaded <= nxt.seg_loaded;
        in_reloc_code <= nxt.reloc_code;
        in_has_symbol <= nxt.has_sym;
        in_symbol_value <= nxt.sym;
        in_section_address <= nxt.sect;
        in_reloc_offset <= nxt.off;
        in_addend <= nxt.addend;
        start <= 1'b1;
        n_issued++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: checks results, then predicts the request taken at this edge
  always @(posedge clk) begin : watch
    patch_t     want;
    reloc_req_t seen;
    if (rst_n) begin
      if (out_valid) begin
        if (patch_due.size() == 0) begin
          flag_mismatch("result with nothing outstanding", out_write_value, '0);
        end else begin
          want = patch_due.pop_front();
          if (out_status !== want.status)
            flag_mismatch("status", 64'(out_status), 64'(want.status));
          if (out_write_kind !== want.kind)
            flag_mismatch("write_kind", 64'(out_write_kind), 64'(want.kind));
          if (out_write_address !== want.addr)
            flag_mismatch("write_address", out_write_address, want.addr);
          if (out_write_value !== want.value)
            flag_mismatch("write_value", out_write_value, want.value);
        end
      end
      if (start && !busy) begin
        seen = {in_operation, in_slot_index, in_seg_start, in_seg_end, in_seg_loaded,
                in_reloc_code, in_has_symbol, in_symbol_value, in_section_address,
                in_reloc_offset, in_addend};
        patch_due.push_back(predict_patch(seen));
        n_accepted++;
      end
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] small_signed();
    return 64'($urandom_range(8191)) - 64'd4096;
  endfunction

  function automatic logic [63:0] pc_bound();
    case ($urandom_range(5))
      0: return I32_MAX;
      1: return I32_MIN;
      2: return I32_MAX + 64'd1;
      3: return I32_MIN - 64'd1;
      4: return small_signed();
      default: return rnd64();
    endcase
  endfunction

  function automatic logic [63:0] pick_addr();
    int          s;
    logic [63:0] span;
    s = $urandom_range(7);
    span = lay_end[s] - lay_start[s];
    case ($urandom_range(9))
      0: return lay_start[s];
      1: return lay_end[s] - 64'd1;
      2: return lay_end[s];
      3: return lay_start[s] - 64'd1;
      4: return rnd64();
      default: return (lay_end[s] > lay_start[s]) ? lay_start[s] + rnd64() % span
                                                    : lay_start[s];
    endcase
  endfunction

  task automatic push_slot(input int i, input logic [63:0] s, input logic [63:0] e,
                           input logic [63:0] l);
    reloc_req_t r;
    r = '0;
    r.op = OP_SLOT_WRITE;
    r.slot = 3'(i);
    r.seg_start = s;
    r.seg_end = e;
    r.seg_loaded = l;
    r.reloc_code = $urandom;
    r.has_sym = 1'($urandom_range(1));
    r.sym = rnd64();
    r.sect = rnd64();
    r.off = rnd64();
    r.addend = rnd64();
    lay_start[i] = s;
    lay_end[i] = e;
    req_backlog.push_back(r);
  endtask

  task automatic push_reloc(input logic [31:0] ty, input logic has, input logic [63:0] sym,
                            input logic [63:0] sect, input logic [63:0] off,
                            input logic [63:0] add);
    reloc_req_t r;
    r.op = OP_RELOCATE;
    r.slot = 3'($urandom);
    r.seg_start = rnd64();
    r.seg_end = rnd64();
    r.seg_loaded = rnd64();
    r.reloc_code = ty;
    r.has_sym = has;
    r.sym = sym;
    r.sect = sect;
    r.off = off;
    r.addend = add;
    req_backlog.push_back(r);
  endtask

  task automatic push_random_slot(input int i);
    logic [63:0] s;
    logic [63:0] e;
    logic [63:0] l;
    l = {32'h0000_7F00 | 32'($urandom_range(255)), $urandom};
    case ($urandom_range(9))
      0: begin
        s = rnd64();
        e = s + rnd64() % 64'h10_0000;
        l = rnd64();
      end
      1: begin
        s = 64'h40_0000 + (64'(i) << 21);
        e = s + 64'h8000;
        l = '0;
      end
      2: begin
        s = lay_start[(i + 7) % 8] + 64'h100;
        e = s + 64'h4_0000;
      end
      3: begin
        s = 64'hFFFF_FFFF_FFFF_0000;
        e = '1;
      end
      4: begin
        s = 64'h3F_F000;
        e = 64'h40_1000;
      end
      5: begin
        s = 64'h40_0000 + (64'(i) << 21);
        e = s - 64'd1;
      end
      default: begin
        s = 64'h40_0000 + (64'(i) << 21) + 64'($urandom_range(16'hFFFF));
        e = s + 64'($urandom_range(32'h1000, 32'h10_0000));
      end
    endcase
    push_slot(i, s, e, l);
  endtask

  task automatic push_random_reloc();
    logic [31:0] ty;
    logic        has;
    logic [63:0] tgt;
    logic [63:0] sym;
    logic [63:0] sect;
    logic [63:0] add;
    tgt = pick_addr();
    case ($urandom_range(3))
      0: sect = rnd64();
      1: sect = tgt;
      default: sect = tgt - 64'($urandom_range(4095));
    endcase
    case ($urandom_range(11))
      0: ty = RT_NONE;
      1: ty = RT_64;
      2: ty = RT_PC32;
      3: ty = RT_PLT32;
      4: ty = RT_RELATIVE;
      5: ty = RT_GOTPCREL;
      6: ty = RT_32;
      7: ty = RT_32S;
      8: ty = RT_RELATIVE;
      9: ty = RT_PC32;
      10: ty = $urandom;
      default: ty = $urandom_range(12, 63);
    endcase
    has = ($urandom_range(99) < 75);
    sym = ($urandom_range(99) < 12) ? '0 : pick_addr();
    add = ($urandom_range(1) != 0) ? small_signed() : rnd64();
    if ((ty == RT_PC32 || ty == RT_PLT32 || ty == RT_GOTPCREL) &&
        $urandom_range(99) < 60) begin
      // symbol at the target itself: the difference is the addend
      sym = tgt;
      has = 1'b1;
      add = pc_bound();
    end else if (ty == RT_RELATIVE) begin
      case ($urandom_range(4))
        0: add = VADDR_HINT;
        1: add = VADDR_HINT - 64'd1;
        2: add = rnd64();
        default: add = pick_addr();
      endcase
    end else if ($urandom_range(3) == 0) begin
      add = pc_bound();
    end
    push_reloc(ty, has, sym, sect, tgt - sect, add);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SEG_COUNT) map_count = val[3:0];
    else map_load_base = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (req_backlog.size() != 0 || patch_due.size() != 0 || start)
      @(posedge clk);
  endtask

  initial begin
    logic [3:0]  cnt_plan [6];
    logic [63:0] base_plan [6];
    cnt_plan = '{4'd8, 4'd15, 4'd1, 4'd5, 4'd9, 4'd8};
    base_plan = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, rnd64(), 64'h8000_0000_0000_0000,
                  rnd64(), rnd64()};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idle_pct = 28;
    write_reg(CFG_SEG_COUNT, 64'd0);
    write_reg(CFG_LOAD_BASE, 64'd0);
    // nothing searched yet
    push_reloc(RT_64, 1'b0, '0, 64'h40_0000, 64'h10, 64'h5);
    push_slot(0, 64'h40_0000, 64'h50_0000, 64'h7F00_0000_0000);
    push_slot(1, 64'h60_0000, 64'h70_0000, 64'h0);
    push_slot(2, 64'h1000, 64'h3000, 64'h10_0000_0000);
    push_slot(3, 64'hFFFF_FFFF_FFFF_F000, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000);
    push_slot(4, 64'h80_0000, 64'h90_0000, 64'h8000_0000);
    for (int i = 5; i < 8; i++)
      push_slot(i, 64'h100_0000 * i, 64'h100_0000 * i + 64'h1_0000,
                64'h5555_0000_0000 + (64'(i) << 20));
    drain();
    write_reg(CFG_SEG_COUNT, 64'd8);
    write_reg(CFG_LOAD_BASE, 64'hFFFF_0000_0000_1000);

    push_reloc(RT_NONE, 1'b1, 64'h40_0100, 64'h40_0000, 64'h0, 64'h0);
    // section address wraps around into slot 0
    push_reloc(RT_64, 1'b1, 64'h40_1000, '1, 64'h40_0001, 64'h7FFF_FFFF_FFFF_FFFF);
    push_reloc(RT_PC32, 1'b1, 64'h40_0000, 64'h40_0100, 64'h0, -64'sd4);
    push_reloc(RT_PLT32, 1'b1, 64'h40_0000, 64'h80_0000, 64'h0, 64'h0);
    push_reloc(RT_GOTPCREL, 1'b1, 64'h40_0000, 64'h40_0000, 64'h0, I32_MAX);
    push_reloc(RT_PC32, 1'b1, 64'h40_0000, 64'h40_0000, 64'h0, I32_MAX + 64'd1);
    push_reloc(RT_PLT32, 1'b1, 64'h40_0000, 64'h40_0000, 64'h0, I32_MIN);
    push_reloc(RT_PC32, 1'b1, 64'h40_0000, 64'h40_0000, 64'h0, I32_MIN - 64'd1);
    push_reloc(RT_32, 1'b0, 64'h40_0000, 64'h40_0000, 64'h8, 64'h8000_0000_0000_0000);
    push_reloc(RT_32S, 1'b1, 64'h1000, 64'h40_0000, 64'h8, '1);
    push_reloc(RT_RELATIVE, 1'b0, '0, 64'h40_0000, 64'h10, VADDR_HINT);
    push_reloc(RT_RELATIVE, 1'b0, '0, 64'h40_0000, 64'h18, VADDR_HINT - 64'd1);
    push_reloc(RT_RELATIVE, 1'b0, '0, 64'h40_0000, 64'h20, '1);
    // addend translates to zero and is still used
    push_reloc(RT_RELATIVE, 1'b0, '0, 64'h40_0000, 64'h28, 64'h60_0000);
    push_reloc(RT_RELATIVE, 1'b0, '0, 64'h40_0000, 64'h30, 64'h50_0000);
    push_reloc(32'd3, 1'b1, 64'h40_0000, 64'h40_0000, 64'h38, 64'h0);
    push_reloc(32'hFFFF_FFFF, 1'b0, '0, 64'h40_0000, 64'h40, 64'h0);
    push_reloc(RT_64, 1'b0, '0, 64'h60_0000, 64'h0, 64'h0);
    push_reloc(RT_64, 1'b0, '0, 64'h50_0000, 64'h0, 64'h0);
    push_reloc(RT_64, 1'b1, 64'h50_0000, 64'h40_0000, 64'h48, 64'h0);
    push_reloc(RT_64, 1'b1, 64'h60_0000, 64'h40_0000, 64'h50, 64'h0);
    push_reloc(RT_64, 1'b0, 64'h50_0000, 64'h40_0000, 64'h58, 64'h1);
    push_reloc(32'd12, 1'b1, 64'h2FFF, 64'hFFFF_FFFF_FFFF_FFFE, 64'h0, 64'h0);
    drain();

    for (int b = 0; b < 6; b++) begin
      idle_pct = (b < 2) ? 28 : (b < 4) ? 59 : 0;
      write_reg(CFG_SEG_COUNT, 64'(cnt_plan[b]));
      write_reg(CFG_LOAD_BASE, base_plan[b]);
      for (int s = 0; s < 8; s++)
        push_random_slot(s);
      for (int k = 0; k < 210; k++) begin
        if ($urandom_range(99) < 12) push_random_slot($urandom_range(7));
        else push_random_reloc();
      end
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== elf_relocation_patcher_core.f =====
rtl/elfrel_pkg.sv
rtl/elf_relocation_patcher_core.sv
bench/tb_elf_relocation_patcher_core.sv
